// ===== hw/rtl/mrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_pkg
// Types and constants shared by the mesh route table files.
// ----------------------------------------------------------------------------
package mrt_pkg;

    localparam logic       FUNC_ADD    = 1'b0;
    localparam logic       FUNC_LOOKUP = 1'b1;

    localparam logic [1:0] OUT_IGNORED  = 2'd0;
    localparam logic [1:0] OUT_UPDATED  = 2'd1;
    localparam logic [1:0] OUT_KEPT     = 2'd2;
    localparam logic [1:0] OUT_INSERTED = 2'd3;

    localparam logic [1:0] CFG_OWN_ADDR   = 2'd0;
    localparam logic [1:0] CFG_BCAST_ADDR = 2'd1;
    localparam logic [1:0] CFG_NO_ADDR    = 2'd2;

    localparam logic [15:0] OWN_ADDR_RST   = 16'h0000;
    localparam logic [15:0] BCAST_ADDR_RST = 16'hFFFF;
    localparam logic [15:0] NO_ADDR_RST    = 16'h0000;
    localparam logic [7:0]  CLASS_MISS     = 8'd255;

    typedef struct packed {
        logic        func;
        logic [15:0] dest;
        logic [15:0] next_hop;
        logic [7:0]  traffic_class;
        logic [7:0]  route_cost;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [15:0] hop_out;
        logic [7:0]  class_out;
        logic [7:0]  cost_out;
        logic [1:0]  add_outcome;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] data;
    } t_cfg_item;

    // search token walking down the cell chain
    typedef struct packed {
        logic        vld;
        logic        func;
        logic        ign;
        logic [15:0] dest;
        logic [15:0] hop;
        logic [7:0]  tc;
        logic [7:0]  cost;
        logic        hit;
        logic [15:0] hit_hop;
        logic [7:0]  hit_class;
        logic [7:0]  hit_cost;
        logic [1:0]  outcome;
    } t_tok;

    typedef struct packed {
        logic [15:0] dest;
        logic [15:0] hop;
        logic [7:0]  tc;
        logic [7:0]  cost;
    } t_wr;

endpackage

// ===== hw/rtl/mrt_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_ifs
// Valid/ready channels of the mesh route table.
// ----------------------------------------------------------------------------
interface mrt_in_if
    import mrt_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface mrt_out_if
    import mrt_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface mrt_cfg_if
    import mrt_pkg::*;
();
    logic      valid;
    logic      ready;
    t_cfg_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== hw/rtl/mrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_cell
// One route entry; matches and updates the passing token, then forwards it.
// ----------------------------------------------------------------------------
module mrt_cell
    import mrt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_hold,
    input  logic i_wr_en,
    input  t_wr  i_wr,
    input  t_tok i_tok,
    output t_tok o_tok
);

    logic        r_valid;
    logic [15:0] r_dest;
    logic [15:0] r_hop;
    logic [7:0]  r_class;
    logic [7:0]  r_cost;
    t_tok        r_tok;
    t_tok        n_tok;
    logic        match;
    logic        upd;

    always_comb begin
        match = i_tok.vld && r_valid && (r_dest == i_tok.dest) && !i_tok.hit
                && !((i_tok.func == FUNC_ADD) && i_tok.ign);
        upd   = 1'b0;
        n_tok = i_tok;
        if (match) begin
            n_tok.hit = 1'b1;
            if (i_tok.func == FUNC_LOOKUP) begin
                n_tok.hit_hop   = r_hop;
                n_tok.hit_class = r_class;
                n_tok.hit_cost  = r_cost;
            end else if (r_cost >= i_tok.cost) begin
                upd           = 1'b1;
                n_tok.outcome = OUT_UPDATED;
            end else begin
                n_tok.outcome = OUT_KEPT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.vld <= 1'b0;
        end else if (!i_hold) begin
            r_tok <= n_tok;
            if (i_wr_en) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_hold) begin
            if (i_wr_en) begin
                r_dest  <= i_wr.dest;
                r_hop   <= i_wr.hop;
                r_class <= i_wr.tc;
                r_cost  <= i_wr.cost;
            end else if (upd) begin
                r_hop   <= i_tok.hop;
                r_class <= i_tok.tc;
                r_cost  <= i_tok.cost;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== hw/rtl/mesh_route_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_route_table_top
// Routing table keyed by destination: a chain of entry cells searched by a
// token, with round-robin insertion when an add leaves the end of the chain unmatched.
//
//   port     dir   payload                                     accepted when
//   i_in     in    func, dest, next_hop, traffic_class, cost   valid & ready
//   o_out    out   found, hop_out, class_out, cost_out, outcome valid & ready
//   i_cfg    in    register index, 16-bit data                 valid (ready=1)
//
// An item walks one cell per cycle while the output does not stall; a new
// item is taken only after the last one has been loaded into the output
// register, so only one item is in the chain at a time.
// Reset clears entry valid bits, the insert pointer and the busy and output valid flags.
// A stalled output holds the token in the last cell until the register frees.
// ----------------------------------------------------------------------------
module mesh_route_table_top
    import mrt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mrt_in_if.sink     i_in,
    mrt_out_if.source  o_out,
    mrt_cfg_if.sink    i_cfg
);

    localparam int PTR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [15:0]      r_own;
    logic [15:0]      r_bcast;
    logic [15:0]      r_noaddr;
    logic             r_busy;
    logic [PTR_W-1:0] r_ptr;
    logic             r_out_vld;
    t_out_item        r_out;
    t_out_item        n_out;

    t_tok             tok [TABLE_DEPTH+1];
    t_tok             tok_end;
    t_wr              wr;
    logic             accept;
    logic             load;
    logic             hold;
    logic             insert;

    // config
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own    <= OWN_ADDR_RST;
            r_bcast  <= BCAST_ADDR_RST;
            r_noaddr <= NO_ADDR_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.item.index)
                CFG_OWN_ADDR:   r_own    <= i_cfg.item.data;
                CFG_BCAST_ADDR: r_bcast  <= i_cfg.item.data;
                CFG_NO_ADDR:    r_noaddr <= i_cfg.item.data;
                default: ;
            endcase
        end
    end

    // launch
    assign i_in.ready = !r_busy;
    assign accept     = i_in.valid && !r_busy;

    always_comb begin
        tok[0]           = '0;
        tok[0].vld       = accept;
        tok[0].func      = i_in.item.func;
        tok[0].dest      = i_in.item.dest;
        tok[0].hop       = i_in.item.next_hop;
        tok[0].tc        = i_in.item.traffic_class;
        tok[0].cost      = i_in.item.route_cost;
        tok[0].ign       = (i_in.item.dest == r_own) || (i_in.item.dest == r_bcast)
                           || (i_in.item.dest == r_noaddr);
        tok[0].outcome   = OUT_IGNORED;
    end

    // cell chain
    assign tok_end = tok[TABLE_DEPTH];
    assign load    = tok_end.vld && (!r_out_vld || o_out.ready);
    assign hold    = tok_end.vld && !load;
    assign insert  = load && (tok_end.func == FUNC_ADD) && !tok_end.ign && !tok_end.hit;

    assign wr.dest = tok_end.dest;
    assign wr.hop  = tok_end.hop;
    assign wr.tc   = tok_end.tc;
    assign wr.cost = tok_end.cost;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        mrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_hold  (hold),
            .i_wr_en (insert && (r_ptr == PTR_W'(g))),
            .i_wr    (wr),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1])
        );
    end

    // result
    always_comb begin
        n_out = '0;
        if (tok_end.func == FUNC_LOOKUP) begin
            n_out.found     = tok_end.hit;
            n_out.hop_out   = tok_end.hit ? tok_end.hit_hop   : r_noaddr;
            n_out.class_out = tok_end.hit ? tok_end.hit_class : CLASS_MISS;
            n_out.cost_out  = tok_end.hit ? tok_end.hit_cost  : 8'd0;
        end else if (tok_end.ign) begin
            n_out.add_outcome = OUT_IGNORED;
        end else if (tok_end.hit) begin
            n_out.add_outcome = tok_end.outcome;
        end else begin
            n_out.add_outcome = OUT_INSERTED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_ptr     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (load) begin
                r_busy <= 1'b0;
            end
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            if (insert) begin
                r_ptr <= (r_ptr == PTR_W'(TABLE_DEPTH - 1)) ? '0 : r_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.item  = r_out;

endmodule

// ===== hw/rtl/mrt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_checker
// Port-level checks of the mesh route table, bound to the top level.
// ----------------------------------------------------------------------------
module mrt_checker
    import mrt_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_found,
    input logic [1:0] i_out_outcome
);

    // one item in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted while an item is in flight");

    // a lookup hit never carries an add outcome
    a_hit_no_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_found) |-> (i_out_outcome == OUT_IGNORED))
        else $error("found result with add outcome");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // pending result stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

endmodule

bind mesh_route_table_top mrt_checker u_mrt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_found   (o_out.item.found),
    .i_out_outcome (o_out.item.add_outcome)
);

// ===== tb/sv/mesh_route_table_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_route_table_top_tb
// Self-checking bench for the mesh route table. A local route table tracks
// every accepted add and lookup and queues the result the block should give.
// Each output item is checked in order, field by field. Directed items cover
// an empty table, the update/keep rules, reserved addresses and their change
// at run time. Random phases follow under new register settings, with random
// gaps on both channels. A final streaming phase runs with no gaps.
// ----------------------------------------------------------------------------
module mesh_route_table_top_tb;
    import mrt_pkg::*;

    localparam int         TABLE_DEPTH = 16;
    localparam int         STALL_LIMIT = 2000;
    localparam int         SETTLE      = TABLE_DEPTH + 4;
    localparam logic [1:0] CFG_SPARE   = 2'd3;

    logic i_clk;
    logic i_rst_n;

    mrt_in_if  in_if ();
    mrt_out_if out_if ();
    mrt_cfg_if cfg_if ();

    mesh_route_table_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // local route table
    logic        route_valid [TABLE_DEPTH];
    logic [15:0] route_dest  [TABLE_DEPTH];
    logic [15:0] route_hop   [TABLE_DEPTH];
    logic [7:0]  route_class [TABLE_DEPTH];
    logic [7:0]  route_cost  [TABLE_DEPTH];
    int          insert_slot;
    logic [15:0] own_addr_reg;
    logic [15:0] bcast_addr_reg;
    logic [15:0] no_addr_reg;

    t_out_item   expected_results[$];
    logic [15:0] dest_pool[24];

    int  error_count;
    int  item_count;
    int  lookup_count;
    int  hit_count;
    int  outcome_count[4];
    int  wrap_count;
    int  cfg_write_count;
    bit  no_idle;
    bit  feed_on;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_in_item make_item(logic func, logic [15:0] dest, logic [15:0] hop,
                                           logic [7:0] tc, logic [7:0] cost);
        t_in_item it;
        it.func          = func;
        it.dest          = dest;
        it.next_hop      = hop;
        it.traffic_class = tc;
        it.route_cost    = cost;
        return it;
    endfunction

    function automatic t_out_item predict_route_result(t_in_item it);
        t_out_item res;
        int        slot;
        res  = '0;
        slot = -1;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (route_valid[i] && route_dest[i] == it.dest) slot = i;
        end
        if (it.func == FUNC_LOOKUP) begin
            if (slot >= 0) begin
                res.found     = 1'b1;
                res.hop_out   = route_hop[slot];
                res.class_out = route_class[slot];
                res.cost_out  = route_cost[slot];
            end else begin
                res.hop_out   = no_addr_reg;
                res.class_out = CLASS_MISS;
            end
        end else if (it.dest == own_addr_reg || it.dest == bcast_addr_reg ||
                     it.dest == no_addr_reg) begin
            res.add_outcome = OUT_IGNORED;
        end else if (slot >= 0) begin
            if (route_cost[slot] >= it.route_cost) begin
                route_hop[slot]   = it.next_hop;
                route_class[slot] = it.traffic_class;
                route_cost[slot]  = it.route_cost;
                res.add_outcome   = OUT_UPDATED;
            end else begin
                res.add_outcome = OUT_KEPT;
            end
        end else begin
            route_valid[insert_slot] = 1'b1;
            route_dest[insert_slot]  = it.dest;
            route_hop[insert_slot]   = it.next_hop;
            route_class[insert_slot] = it.traffic_class;
            route_cost[insert_slot]  = it.route_cost;
            if (insert_slot == TABLE_DEPTH - 1) begin
                insert_slot = 0;
                wrap_count++;
            end else begin
                insert_slot++;
            end
            res.add_outcome = OUT_INSERTED;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic stop_feed();
        if (feed_on) begin
            in_if.valid <= 1'b0;
            feed_on = 1'b0;
        end
    endtask

    task automatic idle_input(int cycles);
        stop_feed();
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain_results();
        stop_feed();
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // sends one item; returns the result it should produce
    task automatic send_route_item(input t_in_item it, output t_out_item res);
        in_if.valid <= 1'b1;
        in_if.item  <= it;
        feed_on = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        res = predict_route_result(it);
        expected_results.push_back(res);
        item_count++;
        if (it.func == FUNC_LOOKUP) begin
            lookup_count++;
            if (res.found) hit_count++;
        end else begin
            outcome_count[res.add_outcome]++;
        end
    endtask

    task automatic send_directed(logic func, logic [15:0] dest, logic [15:0] hop,
                                 logic [7:0] tc, logic [7:0] cost);
        t_out_item res;
        send_route_item(make_item(func, dest, hop, tc, cost), res);
        if (!no_idle && $urandom_range(0, 2) == 0) idle_input($urandom_range(1, 19));
    endtask

    task automatic write_register(logic [1:0] idx, logic [15:0] data);
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        cfg_if.valid      <= 1'b1;
        cfg_if.item.index <= idx;
        cfg_if.item.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        cfg_write_count++;
        case (idx)
            CFG_OWN_ADDR:   own_addr_reg   = data;
            CFG_BCAST_ADDR: bcast_addr_reg = data;
            CFG_NO_ADDR:    no_addr_reg    = data;
            default: ;
        endcase
    endtask

    function automatic logic [15:0] pick_address();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic fill_dest_pool();
        dest_pool[0] = own_addr_reg;
        dest_pool[1] = bcast_addr_reg;
        dest_pool[2] = no_addr_reg;
        for (int i = 3; i < 24; i++) dest_pool[i] = 16'($urandom_range(0, 65535));
    endtask

    // random adds and lookups until the block has done real work on `useful` items
    task automatic run_traffic(int useful);
        t_in_item  it;
        t_out_item res;
        int        done;
        done = 0;
        fill_dest_pool();
        while (done < useful) begin
            it = make_item($urandom_range(0, 9) < 4 ? FUNC_LOOKUP : FUNC_ADD,
                           $urandom_range(0, 9) < 7 ? dest_pool[$urandom_range(0, 23)]
                                                    : 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
            send_route_item(it, res);
            if (it.func == FUNC_LOOKUP || res.add_outcome != OUT_IGNORED) begin
                done++;
                if (done == useful / 2) drain_results();
            end
            if (!no_idle && $urandom_range(0, 7) == 0) idle_input($urandom_range(1, 19));
        end
    endtask

    task automatic test_empty_table();
        send_directed(FUNC_LOOKUP, 16'h0000, 16'h1111, 8'h11, 8'h11);
        send_directed(FUNC_LOOKUP, 16'hFFFF, 16'h0000, 8'h00, 8'h00);
        send_directed(FUNC_ADD, 16'h0000, 16'hFFFF, 8'hFF, 8'hFF);
        send_directed(FUNC_ADD, 16'hFFFF, 16'h0000, 8'h00, 8'h00);
    endtask

    task automatic test_route_updates();
        send_directed(FUNC_ADD, 16'h5A5A, 16'hFFFF, 8'hFF, 8'd100);
        send_directed(FUNC_LOOKUP, 16'h5A5A, 16'h0000, 8'h00, 8'h00);
        send_directed(FUNC_ADD, 16'h5A5A, 16'h1234, 8'h34, 8'd100);
        send_directed(FUNC_ADD, 16'h5A5A, 16'hABCD, 8'hCD, 8'd200);
        send_directed(FUNC_ADD, 16'h5A5A, 16'h0000, 8'h00, 8'd0);
        send_directed(FUNC_ADD, 16'h8001, 16'h0000, 8'h00, 8'hFF);
        send_directed(FUNC_ADD, 16'hFFFE, 16'hFFFF, 8'hFF, 8'h00);
        send_directed(FUNC_LOOKUP, 16'h8001, 16'hFFFF, 8'hFF, 8'hFF);
        send_directed(FUNC_LOOKUP, 16'hFFFE, 16'h0000, 8'h00, 8'h00);
    endtask

    task automatic test_reserved_addresses();
        // route stays and answers lookups after its address becomes reserved
        write_register(CFG_OWN_ADDR, 16'h5A5A);
        send_directed(FUNC_ADD, 16'h5A5A, 16'h7777, 8'h77, 8'h00);
        send_directed(FUNC_LOOKUP, 16'h5A5A, 16'h0000, 8'h00, 8'h00);
        write_register(CFG_BCAST_ADDR, 16'h0000);
        write_register(CFG_NO_ADDR, 16'hFFFF);
        write_register(CFG_SPARE, 16'h1234);
        send_directed(FUNC_ADD, 16'h0000, 16'h4444, 8'h44, 8'h44);
        send_directed(FUNC_ADD, 16'hFFFF, 16'h4444, 8'h44, 8'h44);
        send_directed(FUNC_LOOKUP, 16'hFFFF, 16'h0000, 8'h00, 8'h00);
        write_register(CFG_OWN_ADDR, 16'h0000);
        send_directed(FUNC_ADD, 16'h5A5A, 16'h9999, 8'h99, 8'h00);
        write_register(CFG_OWN_ADDR, 16'hFFFF);
        write_register(CFG_BCAST_ADDR, 16'hFFFF);
        write_register(CFG_NO_ADDR, 16'h0000);
        send_directed(FUNC_ADD, 16'h0000, 16'h4444, 8'h44, 8'h44);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++) begin
            write_register(CFG_OWN_ADDR, phase == 0 ? 16'h0000 : pick_address());
            write_register(CFG_BCAST_ADDR, phase == 0 ? 16'hFFFF : pick_address());
            write_register(CFG_NO_ADDR, phase == 0 ? 16'h0000 : pick_address());
            run_traffic(200);
        end
    endtask

    task automatic test_streaming();
        write_register(CFG_OWN_ADDR, pick_address());
        write_register(CFG_NO_ADDR, pick_address());
        no_idle = 1'b1;
        run_traffic(200);
    endtask

    // output side: random stalls, in-order check against the queue
    initial begin
        t_out_item want;
        int        stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, hop", out_if.item.hop_out, 16'h0);
                end else begin
                    want = expected_results.pop_front();
                    if (out_if.item.found !== want.found)
                        report_mismatch("found", 16'(out_if.item.found), 16'(want.found));
                    if (out_if.item.hop_out !== want.hop_out)
                        report_mismatch("hop_out", out_if.item.hop_out, want.hop_out);
                    if (out_if.item.class_out !== want.class_out)
                        report_mismatch("class_out", 16'(out_if.item.class_out),
                                        16'(want.class_out));
                    if (out_if.item.cost_out !== want.cost_out)
                        report_mismatch("cost_out", 16'(out_if.item.cost_out),
                                        16'(want.cost_out));
                    if (out_if.item.add_outcome !== want.add_outcome)
                        report_mismatch("add_outcome", 16'(out_if.item.add_outcome),
                                        16'(want.add_outcome));
                end
            end
            if (no_idle) stall_left = 0;
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no accepted item on any channel
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[%0t] watchdog: no progress for %0d cycles", $realtime,
                         STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        error_count     = 0;
        item_count      = 0;
        lookup_count    = 0;
        hit_count       = 0;
        wrap_count      = 0;
        cfg_write_count = 0;
        no_idle         = 1'b0;
        feed_on         = 1'b0;
        for (int i = 0; i < 4; i++) outcome_count[i] = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            route_valid[i] = 1'b0;
            route_dest[i]  = '0;
            route_hop[i]   = '0;
            route_class[i] = '0;
            route_cost[i]  = '0;
        end
        insert_slot    = 0;
        own_addr_reg   = OWN_ADDR_RST;
        bcast_addr_reg = BCAST_ADDR_RST;
        no_addr_reg    = NO_ADDR_RST;

        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.item   <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.item  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_route_updates();
        test_reserved_addresses();
        test_random_traffic();
        test_streaming();

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch("results never seen, count", 16'(expected_results.size()), 16'h0);

        $display("Covered %0d items: %0d lookups (%0d hits), %0d config writes.",
                 item_count, lookup_count, hit_count, cfg_write_count);
        $display("Adds ignored %0d, updated %0d, kept %0d, inserted %0d; %0d table wraps.",
                 outcome_count[OUT_IGNORED], outcome_count[OUT_UPDATED],
                 outcome_count[OUT_KEPT], outcome_count[OUT_INSERTED], wrap_count);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mrt_pkg.sv
hw/rtl/mrt_ifs.sv
hw/rtl/mrt_cell.sv
hw/rtl/mesh_route_table_top.sv
hw/rtl/mrt_checker.sv
tb/sv/mesh_route_table_top_tb.sv
